>>> hdl/lmr_pkg.sv
// ----------------------------------------------------------------------------
// lmr_pkg: shared types and constants
// Field widths, command codes, register indexes and the queue entry type
// of the LED matrix refresh controller.
// ----------------------------------------------------------------------------
package lmr_pkg;

  // payload widths
  localparam int BYTE_W    = 8;
  localparam int GRID_W    = 4;
  localparam int SEG_W     = 4;
  localparam int CFG_IDX_W = 2;

  // item command codes
  localparam logic CMD_SEGMENT = 1'b0;
  localparam logic CMD_REFRESH = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT = 2'd2;

  // register reset values
  localparam logic [BYTE_W-1:0] MODE_RST   = 8'h02;
  localparam logic [BYTE_W-1:0] DATA_RST   = 8'h40;
  localparam logic [BYTE_W-1:0] BRIGHT_RST = 8'h8F;

  // display address command that opens the cache frame
  localparam logic [BYTE_W-1:0] START_ADDR = 8'hC0;

  // highest 1-based segment position
  localparam logic [SEG_W-1:0] SEG_MAX = 4'd8;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic              refresh;
    logic [GRID_W-1:0] idx;
    logic [2:0]        bit_sel;
    logic              seg_on;
  } entry_t;

endpackage

>>> hdl/lmr_ifs.sv
// ----------------------------------------------------------------------------
// lmr_ifs: channel interfaces
// Input item, result item and configuration write channels, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface lmr_in_if
  import lmr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [GRID_W-1:0] grid_pos;
  logic [SEG_W-1:0]  seg_pos;
  logic              seg_on;

  modport source (output valid, cmd, grid_pos, seg_pos, seg_on, input ready);
  modport sink   (input valid, cmd, grid_pos, seg_pos, seg_on, output ready);
endinterface

interface lmr_out_if
  import lmr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              frame_end;
  logic              last;

  modport source (output valid, out_byte, frame_end, last, input ready);
  modport sink   (input valid, out_byte, frame_end, last, output ready);
endinterface

interface lmr_cfg_if
  import lmr_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/lmr_front.sv
// ----------------------------------------------------------------------------
// lmr_front: input classifier
// Accepts input items, drops out-of-range segment writes and turns the
// rest into queue entries for the back end.
// ----------------------------------------------------------------------------
module lmr_front
  import lmr_pkg::*;
#(
  parameter int CACHE_BYTES = 14
) (
  input  logic   clk,
  input  logic   rst_n,
  lmr_in_if.sink in_ch,
  input  logic   q_full,
  output logic   q_push,
  output entry_t q_entry
);

  logic in_fire;
  logic grid_ok;
  logic seg_ok;
  logic keep;

  // accept whenever the queue has room
  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // range checks on the 1-based positions
  assign grid_ok = (in_ch.grid_pos != '0) &&
                   ({1'b0, in_ch.grid_pos} <= (GRID_W+1)'(CACHE_BYTES));
  assign seg_ok  = (in_ch.seg_pos != '0) && (in_ch.seg_pos <= SEG_MAX);
  assign keep    = (in_ch.cmd == CMD_REFRESH) || (grid_ok && seg_ok);

  // build the queue entry
  always_comb begin
    q_entry.refresh = (in_ch.cmd == CMD_REFRESH);
    q_entry.idx     = in_ch.grid_pos - GRID_W'(1);
    q_entry.bit_sel = 3'(in_ch.seg_pos - SEG_W'(1));
    q_entry.seg_on  = in_ch.seg_on;
  end

  assign q_push = in_fire && keep;

  // every pushed segment write must carry a legal byte index
  a_push_idx_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_entry.refresh) |-> ({1'b0, q_entry.idx} < (GRID_W+1)'(CACHE_BYTES)))
    else $error("segment write pushed with out-of-range index");

  // a full queue never takes a push
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("push while queue full");

  // a refresh is never dropped by the range filter
  a_refresh_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.cmd == CMD_REFRESH) |-> q_push)
    else $error("accepted refresh not queued");

endmodule

>>> hdl/lmr_queue.sv
// ----------------------------------------------------------------------------
// lmr_queue: command queue
// Small in-order FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module lmr_queue
  import lmr_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   full,
  output logic   empty
);

  entry_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> hdl/lmr_back.sv
// ----------------------------------------------------------------------------
// lmr_back: cache and refresh sequencer
// Holds the display cache and configuration registers, applies segment
// writes and streams one refresh frame byte per cycle into the output
// register while the output slot is free.
// ----------------------------------------------------------------------------
module lmr_back
  import lmr_pkg::*;
#(
  parameter int CACHE_BYTES = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  lmr_cfg_if.sink   cfg_ch,
  lmr_out_if.source out_ch,
  input  entry_t    q_head,
  input  logic      q_empty,
  output logic      q_pop
);

  localparam int CNT_W = (CACHE_BYTES > 1) ? $clog2(CACHE_BYTES) : 1;
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CACHE_BYTES - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DATA   = 3'd1;
  localparam logic [2:0] ST_ADDR   = 3'd2;
  localparam logic [2:0] ST_CACHE  = 3'd3;
  localparam logic [2:0] ST_BRIGHT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] cache_r [CACHE_BYTES];
  logic [BYTE_W-1:0] mode_r, data_r, bright_r;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_fe_r, out_fe_nxt;
  logic              out_last_r, out_last_nxt;

  logic              slot_free;
  logic              load;
  logic              cache_we;
  logic [CNT_W-1:0]  widx;
  logic [BYTE_W-1:0] wr_byte;

  // configuration registers, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RST;
      data_r   <= DATA_RST;
      bright_r <= BRIGHT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_MODE:   mode_r   <= cfg_ch.data;
        CFG_DATA:   data_r   <= cfg_ch.data;
        CFG_BRIGHT: bright_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // output slot frees when empty or being taken
  assign slot_free = !out_valid_r || out_ch.ready;

  // segment write: modify one bit of the addressed byte
  assign widx = q_head.idx[CNT_W-1:0];
  always_comb begin
    wr_byte = cache_r[widx];
    wr_byte[q_head.bit_sel] = q_head.seg_on;
  end

  // sequence the refresh frame
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    q_pop        = 1'b0;
    cache_we     = 1'b0;
    load         = 1'b0;
    out_byte_nxt = out_byte_r;
    out_fe_nxt   = out_fe_r;
    out_last_nxt = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_head.refresh) begin
            if (slot_free) begin
              q_pop        = 1'b1;
              load         = 1'b1;
              out_byte_nxt = mode_r;
              out_fe_nxt   = 1'b1;
              out_last_nxt = 1'b0;
              state_nxt    = ST_DATA;
            end
          end else begin
            q_pop    = 1'b1;
            cache_we = 1'b1;
          end
        end
      end
      ST_DATA: begin
        if (slot_free) begin
          load         = 1'b1;
          out_byte_nxt = data_r;
          out_fe_nxt   = 1'b1;
          out_last_nxt = 1'b0;
          state_nxt    = ST_ADDR;
        end
      end
      ST_ADDR: begin
        if (slot_free) begin
          load         = 1'b1;
          out_byte_nxt = START_ADDR;
          out_fe_nxt   = 1'b0;
          out_last_nxt = 1'b0;
          cnt_nxt      = '0;
          state_nxt    = ST_CACHE;
        end
      end
      ST_CACHE: begin
        if (slot_free) begin
          load         = 1'b1;
          out_byte_nxt = cache_r[cnt_r];
          out_fe_nxt   = (cnt_r == LAST_IDX);
          out_last_nxt = 1'b0;
          if (cnt_r == LAST_IDX) begin
            state_nxt = ST_BRIGHT;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_BRIGHT: begin
        if (slot_free) begin
          load         = 1'b1;
          out_byte_nxt = bright_r;
          out_fe_nxt   = 1'b1;
          out_last_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_fe_r   <= out_fe_nxt;
    out_last_r <= out_last_nxt;
  end

  // display cache, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CACHE_BYTES; i++) begin
        cache_r[i] <= '0;
      end
    end else if (cache_we) begin
      cache_r[widx] <= wr_byte;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.frame_end = out_fe_r;
  assign out_ch.last      = out_last_r;

  // the closing byte of a refresh always ends a strobe frame
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_fe_r)
    else $error("last byte without frame end");

  // commands leave the queue only between refreshes
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE))
    else $error("queue pop during refresh");

  // the address step always sends the start address
  a_start_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADDR && load) |=> (out_byte_r == START_ADDR && !out_fe_r))
    else $error("wrong start address byte");

endmodule

>>> hdl/led_matrix_refresh_controller.sv
// ----------------------------------------------------------------------------
// led_matrix_refresh_controller: LED driver display cache and refresh
// A refresh item passes the command queue and the output register first.
// Throughput: a refresh streams CACHE_BYTES + 4 bytes (18 by default), one
//   per cycle from the back-end sequencer while the output slot is free.
// A 4-entry command queue lets input accept during a refresh.
// Reset: synchronous active-low; cache cleared, registers to defaults.
// ----------------------------------------------------------------------------
module led_matrix_refresh_controller
  import lmr_pkg::*;
#(
  parameter int CACHE_BYTES = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  lmr_in_if.sink    in_chan,
  lmr_out_if.source out_chan,
  lmr_cfg_if.sink   cfg_chan
);

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;

  // classify incoming items
  lmr_front #(
    .CACHE_BYTES (CACHE_BYTES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_chan),
    .q_full  (full),
    .q_push  (push),
    .q_entry (push_entry)
  );

  // decouple front and back
  lmr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  // apply writes and stream refresh frames
  lmr_back #(
    .CACHE_BYTES (CACHE_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_chan),
    .out_ch  (out_chan),
    .q_head  (head),
    .q_empty (empty),
    .q_pop   (pop)
  );

endmodule
